/* rtl/midi_track_event_parser_top_assert.svh */
// assertion macros for the midi track event parser top level
// expects clk and rst_n in the scope of use
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define MTEP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MTEP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that holds in the cycle after a reset edge
`define MTEP_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mtep_pkg.sv */
// shared types, codes and constants of the midi track event parser
// no dependencies
`default_nettype none

package mtep_pkg;

  localparam int unsigned VLEN_W = 28;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic CFG_IDX_TRACK_LENGTH = 1'b0;

  localparam logic [1:0] KIND_CHAN  = 2'd0;
  localparam logic [1:0] KIND_SYSEX = 2'd1;
  localparam logic [1:0] KIND_META  = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  localparam logic [7:0] ST_SYSEX  = 8'hf0;
  localparam logic [7:0] ST_ESCAPE = 8'hf7;
  localparam logic [7:0] ST_META   = 8'hff;
  localparam logic [7:0] ST_PROG   = 8'hc0;
  localparam logic [7:0] ST_PRESS  = 8'hd0;

  localparam logic [7:0] MT_SEQNUM  = 8'h00;
  localparam logic [7:0] MT_CHPFX   = 8'h20;
  localparam logic [7:0] MT_PORTPFX = 8'h21;
  localparam logic [7:0] MT_EOT     = 8'h2f;
  localparam logic [7:0] MT_TEMPO   = 8'h51;
  localparam logic [7:0] MT_TIMESIG = 8'h58;
  localparam logic [7:0] MT_KEYSIG  = 8'h59;

  localparam logic [7:0] KEY_SHARPS_MAX = 8'h07;
  localparam logic [7:0] KEY_FLATS_MIN  = 8'hf9;
  localparam logic [7:0] KEY_MODE_MAX   = 8'h01;

  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_SYSLEN   = 4'd4,
    PH_SYSDATA  = 4'd5,
    PH_METATYPE = 4'd6,
    PH_METALEN  = 4'd7,
    PH_METADATA = 4'd8
  } phase_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VLEN_W-1:0] delta_time;
    logic [7:0]        command;
    logic [3:0]        channel;
    logic [7:0]        first_data;
    logic [7:0]        second_data;
    logic [7:0]        meta_code;
    logic [VLEN_W-1:0] meta_length;
    logic [31:0]       meta_value;
    logic              key_valid;
    logic              last_byte;
    logic              track_ended;
  } res_t;

  typedef struct packed {
    logic valid;
    logic ended;
  } core_stat_t;

  // number of leading payload bytes kept for a meta type
  function automatic logic [2:0] meta_cap(input logic [7:0] t);
    logic [2:0] c;
    case (t)
      MT_TEMPO:                        c = 3'd3;
      MT_TIMESIG, MT_KEYSIG, MT_SEQNUM: c = 3'd2;
      MT_CHPFX, MT_PORTPFX:            c = 3'd1;
      MT_EOT:                          c = 3'd0;
      default:                         c = 3'd4;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/mtep_cfg.sv */
// apb-style register file holding the track length
// depends on mtep_pkg
`default_nettype none

module mtep_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mtep_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output logic      [31:0]                     track_length
);
  import mtep_pkg::*;

  logic [31:0] track_length_r;
  logic [31:0] track_length_nxt;
  logic        sel_len;

  assign sel_len = (paddr[CFG_ADDR_W-1] == CFG_IDX_TRACK_LENGTH);

  always_comb begin
    track_length_nxt = track_length_r;
    if (psel && penable && pwrite && sel_len) begin
      track_length_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_length_r <= '0;
    end else begin
      track_length_r <= track_length_nxt;
    end
  end

  assign prdata       = sel_len ? track_length_r : 32'd0;
  assign pready       = 1'b1;
  assign track_length = track_length_r;

endmodule

`default_nettype wire

/* rtl/mtep_core.sv */
// byte-wise track event decoder: parse state and per-byte result
// depends on mtep_pkg
`default_nettype none

module mtep_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire logic [7:0]           in_byte,
  input  wire logic [31:0]          track_length,
  output mtep_pkg::core_stat_t      stat,
  output mtep_pkg::res_t            res
);
  import mtep_pkg::*;

  phase_t            phase_r,  phase_nxt;
  logic [VLEN_W-1:0] va_r,     va_nxt;
  logic [VLEN_W-1:0] hdelta_r, hdelta_nxt;
  logic [7:0]        rs_r,     rs_nxt;
  logic [7:0]        hfirst_r, hfirst_nxt;
  logic [7:0]        hmt_r,    hmt_nxt;
  logic [VLEN_W-1:0] bl_r,     bl_nxt;
  logic [31:0]       pay_r,    pay_nxt;
  logic [31:0]       off_r,    off_nxt;
  logic              ended_r,  ended_nxt;

  logic [VLEN_W-1:0] va_sh;
  logic [VLEN_W-1:0] bl_dec;
  logic [VLEN_W-1:0] got_cnt;
  logic [31:0]       off_inc;
  logic              len_hit;
  logic              rs_short;
  logic              emit;
  logic [1:0]        emit_kind;
  logic              fin;
  logic [VLEN_W-1:0] meta_len;
  logic [7:0]        ks_sf;
  logic [7:0]        ks_mi;

  assign va_sh    = {va_r[VLEN_W-8:0], in_byte[6:0]};
  assign bl_dec   = bl_r - VLEN_W'(1);
  assign got_cnt  = va_r - bl_r;
  assign off_inc  = (off_r == 32'hffff_ffff) ? off_r : off_r + 32'd1;
  assign len_hit  = (off_inc >= track_length);
  assign rs_short = (rs_r[7:5] == ST_PROG[7:5]);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    va_nxt     = va_r;
    hdelta_nxt = hdelta_r;
    rs_nxt     = rs_r;
    hfirst_nxt = hfirst_r;
    hmt_nxt    = hmt_r;
    bl_nxt     = bl_r;
    pay_nxt    = pay_r;
    off_nxt    = off_r;
    ended_nxt  = ended_r;
    emit       = 1'b0;
    emit_kind  = KIND_CHAN;
    fin        = 1'b0;
    if (in_fire && !ended_r) begin
      off_nxt = off_inc;
      case (phase_r)
        PH_DELTA: begin
          va_nxt = va_sh;
          if (!in_byte[7]) begin
            hdelta_nxt = va_sh;
            va_nxt     = '0;
            phase_nxt  = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (!in_byte[7]) begin
            if (rs_r == 8'd0) begin
              emit      = 1'b1;
              emit_kind = KIND_ABORT;
              ended_nxt = 1'b1;
              phase_nxt = PH_DELTA;
            end else begin
              hfirst_nxt = in_byte;
              if (rs_short) begin
                emit = 1'b1;
                fin  = 1'b1;
              end else begin
                phase_nxt = PH_DATA2;
              end
            end
          end else if (in_byte < ST_SYSEX) begin
            rs_nxt    = in_byte;
            phase_nxt = PH_DATA1;
          end else if (in_byte inside {ST_SYSEX, ST_ESCAPE}) begin
            hmt_nxt   = in_byte;
            va_nxt    = '0;
            phase_nxt = PH_SYSLEN;
          end else if (in_byte == ST_META) begin
            phase_nxt = PH_METATYPE;
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_ABORT;
            ended_nxt = 1'b1;
            phase_nxt = PH_DELTA;
          end
        end
        PH_DATA1: begin
          hfirst_nxt = in_byte;
          if (rs_short) begin
            emit = 1'b1;
            fin  = 1'b1;
          end else begin
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          emit = 1'b1;
          fin  = 1'b1;
        end
        PH_SYSLEN: begin
          va_nxt = va_sh;
          if (!in_byte[7]) begin
            bl_nxt = va_sh;
            if (hmt_r == ST_SYSEX) begin
              emit      = 1'b1;
              emit_kind = KIND_SYSEX;
              if (va_sh == '0) begin
                fin = 1'b1;
              end else begin
                phase_nxt = PH_SYSDATA;
              end
            end else if (va_sh == '0) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_SYSDATA;
            end
          end
        end
        PH_SYSDATA: begin
          bl_nxt    = bl_dec;
          emit      = 1'b1;
          emit_kind = KIND_SYSEX;
          if (bl_dec == '0) begin
            fin = 1'b1;
          end
        end
        PH_METATYPE: begin
          hmt_nxt   = in_byte;
          va_nxt    = '0;
          phase_nxt = PH_METALEN;
        end
        PH_METALEN: begin
          va_nxt = va_sh;
          if (!in_byte[7]) begin
            bl_nxt  = va_sh;
            pay_nxt = '0;
            if (va_sh == '0) begin
              emit      = 1'b1;
              emit_kind = KIND_META;
              fin       = 1'b1;
              if (hmt_r == MT_EOT) begin
                ended_nxt = 1'b1;
              end
            end else begin
              phase_nxt = PH_METADATA;
            end
          end
        end
        PH_METADATA: begin
          if (got_cnt < VLEN_W'(meta_cap(hmt_r))) begin
            pay_nxt = {pay_r[23:0], in_byte};
          end
          bl_nxt = bl_dec;
          if (bl_dec == '0) begin
            emit      = 1'b1;
            emit_kind = KIND_META;
            fin       = 1'b1;
            if (hmt_r == MT_EOT) begin
              ended_nxt = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_DELTA;
          va_nxt    = '0;
        end
      endcase
      if (fin) begin
        phase_nxt = PH_DELTA;
        va_nxt    = '0;
        if (len_hit) begin
          ended_nxt = 1'b1;
        end
      end
    end
  end

  assign meta_len = (phase_r == PH_METALEN) ? va_sh : va_r;
  assign ks_sf    = pay_nxt[15:8];
  assign ks_mi    = pay_nxt[7:0];

  // result fields
  always_comb begin
    res             = '0;
    res.kind        = emit_kind;
    res.delta_time  = hdelta_r;
    res.track_ended = ended_nxt;
    case (emit_kind)
      KIND_CHAN: begin
        res.command     = {rs_r[7:4], 4'h0};
        res.channel     = rs_r[3:0];
        res.first_data  = hfirst_nxt;
        res.second_data = (phase_r == PH_DATA2) ? in_byte : 8'd0;
      end
      KIND_SYSEX: begin
        res.first_data = (phase_r == PH_SYSLEN) ? ST_SYSEX : in_byte;
        res.last_byte  = (bl_nxt == '0);
      end
      KIND_META: begin
        res.meta_code   = hmt_r;
        res.meta_length = meta_len;
        res.meta_value  = pay_nxt;
        res.key_valid   = (hmt_r == MT_KEYSIG) && (meta_len >= VLEN_W'(2))
                          && ((ks_sf <= KEY_SHARPS_MAX) || (ks_sf >= KEY_FLATS_MIN))
                          && (ks_mi <= KEY_MODE_MAX);
      end
      default: begin
        res.first_data = in_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_DELTA;
      va_r     <= '0;
      hdelta_r <= '0;
      rs_r     <= '0;
      hfirst_r <= '0;
      hmt_r    <= '0;
      bl_r     <= '0;
      pay_r    <= '0;
      off_r    <= '0;
      ended_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      va_r     <= va_nxt;
      hdelta_r <= hdelta_nxt;
      rs_r     <= rs_nxt;
      hfirst_r <= hfirst_nxt;
      hmt_r    <= hmt_nxt;
      bl_r     <= bl_nxt;
      pay_r    <= pay_nxt;
      off_r    <= off_nxt;
      ended_r  <= ended_nxt;
    end
  end

  assign stat.valid = emit;
  assign stat.ended = ended_r;

endmodule

`default_nettype wire

/* rtl/mtep_outbuf.sv */
// two-entry result buffer between the decoder and the result channel
// depends on mtep_pkg
`default_nettype none

module mtep_outbuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  mtep_pkg::res_t      din,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mtep_pkg::res_t      dout
);
  import mtep_pkg::*;

  res_t       e0_r, e0_nxt;
  res_t       e1_r, e1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b11: begin
        if (cnt_r == 2'd1) begin
          e0_nxt = din;
        end else begin
          e0_nxt = e1_r;
          e1_nxt = din;
        end
      end
      2'b10: begin
        if (cnt_r == 2'd0) begin
          e0_nxt = din;
        end else begin
          e1_nxt = din;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        e0_nxt  = e1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign dout      = e0_r;

endmodule

`default_nettype wire

/* rtl/midi_track_event_parser_top.sv */
// Track chunk body parser for standard midi files. One byte is taken per
// cycle while in_stall is low; the decoder updates its parse state in the
// cycle of the request, and a result, if the byte completes one, is
// presented from a two-entry output buffer. in_stall rises only while that
// buffer holds two results, so a stalled result channel costs throughput
// and nothing else. Bytes after the track has ended are taken and dropped.
// The track length register at address 0 is checked as each event completes.
// top level: depends on mtep_pkg, mtep_cfg, mtep_core, mtep_outbuf and
// midi_track_event_parser_top_assert.svh
`default_nettype none

`include "midi_track_event_parser_top_assert.svh"

module midi_track_event_parser_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_data_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [1:0]                      out_kind,
  output logic      [mtep_pkg::VLEN_W-1:0]     out_delta_time,
  output logic      [7:0]                      out_command,
  output logic      [3:0]                      out_channel,
  output logic      [7:0]                      out_first_data,
  output logic      [7:0]                      out_second_data,
  output logic      [7:0]                      out_meta_code,
  output logic      [mtep_pkg::VLEN_W-1:0]     out_meta_length,
  output logic      [31:0]                     out_meta_value,
  output logic                                 out_key_valid,
  output logic                                 out_last_byte,
  output logic                                 out_track_ended,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mtep_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);
  import mtep_pkg::*;

  logic       [31:0] track_length;
  logic              in_fire;
  core_stat_t        stat;
  res_t              core_res;
  res_t              out_res;

  assign in_fire = in_valid && !in_stall;

  mtep_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .track_length (track_length)
  );

  mtep_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_byte      (in_data_byte),
    .track_length (track_length),
    .stat         (stat),
    .res          (core_res)
  );

  mtep_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stat.valid),
    .din       (core_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_delta_time  = out_res.delta_time;
  assign out_command     = out_res.command;
  assign out_channel     = out_res.channel;
  assign out_first_data  = out_res.first_data;
  assign out_second_data = out_res.second_data;
  assign out_meta_code   = out_res.meta_code;
  assign out_meta_length = out_res.meta_length;
  assign out_meta_value  = out_res.meta_value;
  assign out_key_valid   = out_res.key_valid;
  assign out_last_byte   = out_res.last_byte;
  assign out_track_ended = out_res.track_ended;

  `MTEP_ASSERT_RST(a_reset_empty, !out_valid && !in_stall, "buffer not empty after reset")
  `MTEP_ASSERT_NXT(a_ended_sticky, stat.ended, stat.ended, "track end flag dropped")
  `MTEP_ASSERT_IMP(a_no_result_after_end, stat.valid, !stat.ended, "result after track end")
  `MTEP_ASSERT_IMP(a_abort_ends, out_valid && (out_kind == KIND_ABORT), out_track_ended,
                   "abort result without track end")

endmodule

`default_nettype wire
